[rtl/core/priority_ready_queue_scheduler_assert.svh]
// Assertion macros for the priority ready queue scheduler.
// Each macro expects signals clk and rst to exist in the using module.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define PRQS_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequence that must follow in the same cycle.
`define PRQS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must follow in the next cycle.
`define PRQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/prqs_pkg.sv]
// Shared types and codes for the priority ready queue scheduler.
// No dependencies; used by prqs_cell and priority_ready_queue_scheduler.
`default_nettype none

package prqs_pkg;

  localparam int unsigned MaxThreadsDef     = 16;
  localparam int unsigned PriorityLevelsDef = 4;

  localparam int unsigned TidW  = 4;
  localparam int unsigned PrioW = 2;

  // Request kinds carried in the input word's user field.
  typedef enum logic [1:0] {
    MODE_ACTIVATE = 2'd0,
    MODE_YIELD    = 2'd1,
    MODE_BLOCK    = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  // Result status codes carried in the output word's user field.
  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_PICKED  = 3'd1,
    ST_IDLE    = 3'd2,
    ST_KEEP    = 3'd3,
    ST_DROPPED = 3'd4
  } status_t;

  // One queued thread held by a cell.
  typedef struct packed {
    logic             valid;
    logic [PrioW-1:0] prio;
    logic [TidW-1:0]  tid;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_op_t;

endpackage

`default_nettype wire

[rtl/core/prqs_cell.sv]
// One cell of the sorted ready queue chain: holds a single entry.
// Depends on prqs_pkg for the entry and operation types.
`default_nettype none

module prqs_cell (
  input  wire                clk,
  input  wire                rst,
  input  wire prqs_pkg::cell_op_t op,
  input  wire prqs_pkg::entry_t   left,   // neighbor nearer the head
  input  wire prqs_pkg::entry_t   right,  // neighbor nearer the tail
  output prqs_pkg::entry_t   own
);

  prqs_pkg::entry_t own_next;
  logic             left_ge;
  logic             right_ge;
  logic             own_ge;

  // Priority comparisons against the incoming thread.
  assign left_ge  = left.valid  && (left.prio  >= op.item.prio);
  assign right_ge = right.valid && (right.prio >= op.item.prio);
  assign own_ge   = own.valid   && (own.prio   >= op.item.prio);

  // The chain stays sorted by priority, earliest first among equals.
  always_comb begin
    own_next = own;
    if (op.push && op.pop) begin
      // Insert and remove the head in one step.
      if (right_ge) begin
        own_next = right;
      end else if (own_ge) begin
        own_next = op.item;
      end
    end else if (op.push) begin
      if (left_ge && !own_ge) begin
        own_next = op.item;
      end else if (left.valid && !left_ge) begin
        own_next = left;
      end
    end else if (op.pop) begin
      own_next = right;
    end
  end

  // Entry register; only the valid bit needs reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      own.valid <= 1'b0;
    end else begin
      own <= own_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/priority_ready_queue_scheduler.sv]
// Top level of the priority ready queue scheduler: request decode, cell chain,
// occupancy count and output register. Depends on prqs_pkg and prqs_cell.
//
//   channel  dir  tdata                          tuser
//   s_*      in   thread_id[3:0] priority_req[5:4]  mode[1:0]
//   m_*      out  pick_tid[3:0] ready_count[8:4]     status[2:0]
//
// One request is taken per cycle while s_tready is high; its result word appears
// in the next cycle. The chain of MAX_THREADS cells updates at the same edge,
// since each cell only looks at its two neighbors and the broadcast request.
// s_tready drops only while a result word waits and m_tready is low.
// Synchronous reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module priority_ready_queue_scheduler #(
  parameter int unsigned MAX_THREADS     = prqs_pkg::MaxThreadsDef,
  parameter int unsigned PRIORITY_LEVELS = prqs_pkg::PriorityLevelsDef
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // thread_id[3:0], priority_req[5:4], zero pad
  input  wire  [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // pick_tid[3:0], ready_count[8:4], zero pad
  output logic [2:0]  m_tuser    // status[2:0]
);

`include "priority_ready_queue_scheduler_assert.svh"

  localparam int unsigned CntW = $clog2(MAX_THREADS + 1);

  prqs_pkg::entry_t   cells [MAX_THREADS];
  prqs_pkg::entry_t   item;
  prqs_pkg::cell_op_t op;
  prqs_pkg::mode_t    mode;
  prqs_pkg::status_t  status;
  logic [prqs_pkg::TidW-1:0]  tid_in;
  logic [prqs_pkg::PrioW-1:0] prio_in;
  logic [prqs_pkg::PrioW-1:0] prio_sat;
  logic [prqs_pkg::TidW-1:0]  next_tid;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;
  logic             s_accept;
  logic             full;
  logic             empty;
  logic [MAX_THREADS-1:0] valid_vec;

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign mode    = prqs_pkg::mode_t'(s_tuser);
  assign tid_in  = s_tdata[3:0];
  assign prio_in = s_tdata[5:4];
  assign full    = (count == CntW'(MAX_THREADS));
  assign empty   = (count == '0);

  // Priorities beyond the configured levels fold onto the top level.
  always_comb begin
    if (32'(prio_in) >= PRIORITY_LEVELS) begin
      prio_sat = prqs_pkg::PrioW'(PRIORITY_LEVELS - 1);
    end else begin
      prio_sat = prio_in;
    end
  end

  assign item = '{valid: 1'b1, prio: prio_sat, tid: tid_in};

  // Request decode: chain operation, status and picked thread.
  always_comb begin
    op       = '{push: 1'b0, pop: 1'b0, item: item};
    status   = prqs_pkg::ST_QUEUED;
    next_tid = '0;
    case (mode)
      prqs_pkg::MODE_ACTIVATE: begin
        if (full) begin
          status = prqs_pkg::ST_DROPPED;
        end else begin
          op.push = 1'b1;
        end
      end
      prqs_pkg::MODE_YIELD: begin
        if (empty) begin
          status = prqs_pkg::ST_KEEP;
        end else if (full) begin
          status = prqs_pkg::ST_DROPPED;
        end else begin
          op.push = 1'b1;
          op.pop  = 1'b1;
          status  = prqs_pkg::ST_PICKED;
          // The yielding thread wins only over a strictly lower head.
          if (cells[0].prio >= prio_sat) begin
            next_tid = cells[0].tid;
          end else begin
            next_tid = tid_in;
          end
        end
      end
      prqs_pkg::MODE_BLOCK: begin
        if (empty) begin
          status = prqs_pkg::ST_IDLE;
        end else begin
          op.pop   = 1'b1;
          status   = prqs_pkg::ST_PICKED;
          next_tid = cells[0].tid;
        end
      end
      default: begin
        status = prqs_pkg::ST_QUEUED;
      end
    endcase
    if (!s_accept) begin
      op.push = 1'b0;
      op.pop  = 1'b0;
    end
  end

  // Occupancy after the step.
  always_comb begin
    count_next = count;
    if (op.push && !op.pop) begin
      count_next = count + CntW'(1);
    end else if (op.pop && !op.push) begin
      count_next = count - CntW'(1);
    end
  end

  // Chain of cells, head at index zero.
  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    prqs_pkg::entry_t left_n;
    prqs_pkg::entry_t right_n;

    if (i == 0) begin : g_head
      // The head sees a virtual top-priority neighbor ahead of it.
      assign left_n = '{valid: 1'b1, prio: '1, tid: '0};
    end else begin : g_mid
      assign left_n = cells[i-1];
    end

    if (i == MAX_THREADS - 1) begin : g_tail
      assign right_n = '{valid: 1'b0, prio: '0, tid: '0};
    end else begin : g_body
      assign right_n = cells[i+1];
    end

    prqs_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .op    (op),
      .left  (left_n),
      .right (right_n),
      .own   (cells[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  // Count register and result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_accept) begin
      m_tdata <= {7'd0, 5'(count_next), next_tid};
      m_tuser <= status;
    end
  end

  `PRQS_ASSERT_HOLDS(a_count_bound, count <= CntW'(MAX_THREADS), "queue count overflow")
  `PRQS_ASSERT_HOLDS(a_valid_match, $countones(valid_vec) == 32'(count),
                     "cells disagree with count")
  `PRQS_ASSERT_NEXT(a_idle_on_empty, s_accept && mode == prqs_pkg::MODE_BLOCK && empty,
                    m_tvalid && m_tuser == prqs_pkg::ST_IDLE, "empty pick not reported idle")
  `PRQS_ASSERT_IMPLIES(a_head_valid, !empty, cells[0].valid, "nonempty queue has empty head")

endmodule

`default_nettype wire
